// ===== rtl/trapezoid_move_profile_brake_top_macros.svh =====
// Assertion macros shared by the trapezoid move profile RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TRAPEZOID_MOVE_PROFILE_BRAKE_TOP_MACROS_SVH
`define TRAPEZOID_MOVE_PROFILE_BRAKE_TOP_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define TMPB_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TMPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tmpb_pkg.sv =====
// Shared types and constants for the trapezoid move profile block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none

package tmpb_pkg;

	localparam int MAG_W   = 23;
	localparam int PCT_W   = 7;
	localparam int RAMP_W  = 16;
	localparam int DUTY_W  = 16;
	localparam int CFG_W   = 23;
	localparam int IDX_W   = 3;
	localparam int OUT_W   = 24;
	localparam int NUM_W   = 23;
	localparam int PROD_W  = DUTY_W + NUM_W;
	localparam int DIV_STEPS = 16;
	localparam int CNT_W   = $clog2(DIV_STEPS);

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [6:0] PCT_FULL = 7'd100;

	// Register reset values
	localparam logic [MAG_W-1:0]  RST_TARGET    = 23'd360;
	localparam logic [PCT_W-1:0]  RST_MAX_PCT   = 7'd25;
	localparam logic [PCT_W-1:0]  RST_MIN_PCT   = 7'd10;
	localparam logic [RAMP_W-1:0] RST_RAMP_UP   = 16'd100;
	localparam logic [RAMP_W-1:0] RST_RAMP_DOWN = 16'd150;
	localparam logic [PCT_W-1:0]  RST_BRAKE_PCT = 7'd15;
	localparam logic [RAMP_W-1:0] RST_PERIOD    = 16'd60000;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET    = 3'd0,
		REG_MAX_PCT   = 3'd1,
		REG_MIN_PCT   = 3'd2,
		REG_RAMP_UP   = 3'd3,
		REG_RAMP_DOWN = 3'd4,
		REG_BRAKE_PCT = 3'd5,
		REG_PERIOD    = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_PROFILE = 2'd0,
		PH_BRAKE   = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	// What the back end has to drive for one tick
	typedef enum logic [1:0] {
		K_STOP  = 2'd0,
		K_RAMP  = 2'd1,
		K_CONST = 2'd2,
		K_BRAKE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'd0,
		BK_PROD  = 3'd1,
		BK_SCALE = 3'd2,
		BK_MUL   = 3'd3,
		BK_DIV   = 3'd4,
		BK_OUT   = 3'd5
	} back_state_t;

	typedef struct packed {
		logic [MAG_W-1:0]  target;
		logic [PCT_W-1:0]  max_pct;
		logic [PCT_W-1:0]  min_pct;
		logic [RAMP_W-1:0] ramp_up;
		logic [RAMP_W-1:0] ramp_down;
		logic [PCT_W-1:0]  brake_pct;
		logic [RAMP_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [RAMP_W-1:0] x;
		logic [RAMP_W-1:0] d;
		phase_t            phase;
	} job_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              reverse;
		logic              drive_enable;
		phase_t            move_phase;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/tmpb_front.sv =====
// Front end: takes encoder beats, tracks phase and last magnitude, emits jobs.
// Depends on tmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmpb_front #(
	parameter int COUNT_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  restart,
	input  wire logic [COUNT_BITS-1:0] enc_count,
	input  wire tmpb_pkg::cfg_t        cfg,
	input  wire logic                  q_full,
	output logic                       q_push,
	output tmpb_pkg::job_t             q_job
);

	localparam int MagExtW = 33;

	tmpb_pkg::phase_t             phase_q;
	logic [tmpb_pkg::MAG_W-1:0]   last_q;

	logic [COUNT_BITS-1:0]        mag;
	logic [MagExtW-1:0]           mag_w;
	logic [tmpb_pkg::MAG_W-1:0]   cur;
	tmpb_pkg::phase_t             base_phase;
	logic [tmpb_pkg::MAG_W-1:0]   base_last;
	logic [tmpb_pkg::MAG_W-1:0]   remaining;
	logic                         in_down;
	logic                         in_up;
	logic                         up_span;
	logic [tmpb_pkg::RAMP_W-1:0]  x;
	tmpb_pkg::phase_t             next_phase;
	tmpb_pkg::kind_t              kind;
	logic [tmpb_pkg::RAMP_W-1:0]  d;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Saturated magnitude of the signed count
	always_comb begin
		mag   = enc_count[COUNT_BITS-1] ? (~enc_count + 1'b1) : enc_count;
		mag_w = {{(MagExtW-COUNT_BITS){1'b0}}, mag};
		cur   = (mag_w > MagExtW'(tmpb_pkg::MAG_MAX)) ? tmpb_pkg::MAG_MAX
			: mag_w[tmpb_pkg::MAG_W-1:0];
	end

	// Classify the tick and step the phase
	always_comb begin
		base_phase = restart ? tmpb_pkg::PH_PROFILE : phase_q;
		base_last  = restart ? '0 : last_q;
		remaining  = cfg.target - cur;
		in_down    = remaining < {7'd0, cfg.ramp_down};
		in_up      = cur < {7'd0, cfg.ramp_up};
		up_span    = cfg.max_pct > cfg.min_pct;
		x          = in_down ? remaining[tmpb_pkg::RAMP_W-1:0] : cur[tmpb_pkg::RAMP_W-1:0];
		d          = in_down ? cfg.ramp_down : cfg.ramp_up;
		next_phase = base_phase;
		kind       = tmpb_pkg::K_STOP;
		case (base_phase)
			tmpb_pkg::PH_PROFILE: begin
				if (cur >= cfg.target) begin
					next_phase = tmpb_pkg::PH_BRAKE;
					kind       = tmpb_pkg::K_BRAKE;
				end else if (in_down || in_up) begin
					// Ramp speed is zero only with no floor and no rise
					if (cfg.min_pct == '0 && !(x != '0 && up_span)) begin
						next_phase = tmpb_pkg::PH_BRAKE;
						kind       = tmpb_pkg::K_BRAKE;
					end else begin
						kind = tmpb_pkg::K_RAMP;
					end
				end else if (cfg.max_pct == '0 && cfg.min_pct == '0) begin
					next_phase = tmpb_pkg::PH_BRAKE;
					kind       = tmpb_pkg::K_BRAKE;
				end else begin
					kind = tmpb_pkg::K_CONST;
				end
			end
			default: begin
				// Braking or done: settle when the count stops rising
				if (cur <= base_last) begin
					next_phase = tmpb_pkg::PH_DONE;
					kind       = tmpb_pkg::K_STOP;
				end else begin
					kind = tmpb_pkg::K_BRAKE;
				end
			end
		endcase
	end

	assign q_job = '{kind: kind, x: x, d: d, phase: next_phase};

	// Commit phase and magnitude on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tmpb_pkg::PH_PROFILE;
			last_q  <= '0;
		end else if (q_push) begin
			phase_q <= next_phase;
			last_q  <= cur;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tmpb_fifo.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on tmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmpb_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tmpb_pkg::job_t wr_job,
	input  wire logic           pop,
	output tmpb_pkg::job_t      rd_job,
	output logic                full,
	output logic                empty
);

	tmpb_pkg::job_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full   = cnt_q == 2'd2;
	assign empty  = cnt_q == 2'd0;
	assign rd_job = mem_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tmpb_back.sv =====
// Back end: turns a job into a PWM duty with multipliers and a serial divider,
// then holds the result in the output register. Depends on tmpb_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "trapezoid_move_profile_brake_top_macros.svh"

module tmpb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tmpb_pkg::cfg_t cfg,
	input  wire logic           q_empty,
	input  wire tmpb_pkg::job_t q_job,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tmpb_pkg::res_t      out_res
);

	tmpb_pkg::back_state_t          state_q;
	tmpb_pkg::back_state_t          state_d;
	tmpb_pkg::job_t                 job_q;
	logic [tmpb_pkg::NUM_W-1:0]     a_q;
	logic [tmpb_pkg::NUM_W-1:0]     b_q;
	logic [tmpb_pkg::NUM_W-1:0]     den100_q;
	logic [tmpb_pkg::NUM_W-1:0]     num_q;
	logic                           nz_q;
	logic [tmpb_pkg::NUM_W-1:0]     rem_q;
	logic [tmpb_pkg::DUTY_W-1:0]    quo_q;
	logic [tmpb_pkg::CNT_W-1:0]     cnt_q;
	logic                           out_valid_q;
	tmpb_pkg::res_t                 out_q;

	logic                           load_out;
	logic                           last_step;
	logic [tmpb_pkg::PCT_W-1:0]     span;
	logic [tmpb_pkg::NUM_W:0]       sum;
	logic [tmpb_pkg::PROD_W-1:0]    prod;
	logic [tmpb_pkg::NUM_W:0]       trial;
	logic [tmpb_pkg::NUM_W:0]       diff;
	logic                           ge;

	assign last_step = cnt_q == tmpb_pkg::CNT_W'(tmpb_pkg::DIV_STEPS - 1);

	// Sequencer next state
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			tmpb_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = tmpb_pkg::BK_PROD;
				end
			end
			tmpb_pkg::BK_PROD:  state_d = tmpb_pkg::BK_SCALE;
			tmpb_pkg::BK_SCALE: state_d = tmpb_pkg::BK_MUL;
			tmpb_pkg::BK_MUL:   state_d = tmpb_pkg::BK_DIV;
			tmpb_pkg::BK_DIV: begin
				if (last_step) begin
					state_d = tmpb_pkg::BK_OUT;
				end
			end
			tmpb_pkg::BK_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = tmpb_pkg::BK_IDLE;
				end
			end
			default: state_d = tmpb_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmpb_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath arithmetic
	always_comb begin
		span  = (cfg.max_pct > cfg.min_pct) ? (cfg.max_pct - cfg.min_pct) : '0;
		sum   = {1'b0, a_q} + {1'b0, b_q};
		prod  = tmpb_pkg::PROD_W'(cfg.period) * tmpb_pkg::PROD_W'(num_q);
		trial = {rem_q, quo_q[tmpb_pkg::DUTY_W-1]};
		diff  = trial - {1'b0, den100_q};
		ge    = trial >= {1'b0, den100_q};
	end

	// Numerator terms, clamp, product, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			tmpb_pkg::BK_IDLE: begin
				job_q <= q_job;
			end
			tmpb_pkg::BK_PROD: begin
				case (job_q.kind)
					tmpb_pkg::K_RAMP: begin
						a_q      <= tmpb_pkg::NUM_W'(cfg.min_pct) * tmpb_pkg::NUM_W'(job_q.d);
						b_q      <= tmpb_pkg::NUM_W'(job_q.x) * tmpb_pkg::NUM_W'(span);
						den100_q <= tmpb_pkg::NUM_W'(job_q.d)
							* tmpb_pkg::NUM_W'(tmpb_pkg::PCT_FULL);
					end
					tmpb_pkg::K_CONST: begin
						a_q      <= tmpb_pkg::NUM_W'((cfg.max_pct > cfg.min_pct)
							? cfg.max_pct : cfg.min_pct);
						b_q      <= '0;
						den100_q <= tmpb_pkg::NUM_W'(tmpb_pkg::PCT_FULL);
					end
					tmpb_pkg::K_BRAKE: begin
						a_q      <= tmpb_pkg::NUM_W'(cfg.brake_pct);
						b_q      <= '0;
						den100_q <= tmpb_pkg::NUM_W'(tmpb_pkg::PCT_FULL);
					end
					default: begin
						a_q      <= '0;
						b_q      <= '0;
						den100_q <= tmpb_pkg::NUM_W'(tmpb_pkg::PCT_FULL);
					end
				endcase
			end
			tmpb_pkg::BK_SCALE: begin
				nz_q  <= sum != '0;
				num_q <= (sum > {1'b0, den100_q}) ? den100_q : sum[tmpb_pkg::NUM_W-1:0];
			end
			tmpb_pkg::BK_MUL: begin
				rem_q <= prod[tmpb_pkg::PROD_W-1:tmpb_pkg::DUTY_W];
				quo_q <= prod[tmpb_pkg::DUTY_W-1:0];
				cnt_q <= '0;
			end
			tmpb_pkg::BK_DIV: begin
				rem_q <= ge ? diff[tmpb_pkg::NUM_W-1:0] : trial[tmpb_pkg::NUM_W-1:0];
				quo_q <= {quo_q[tmpb_pkg::DUTY_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.duty         <= nz_q ? quo_q : '0;
			out_q.reverse      <= nz_q && (job_q.kind == tmpb_pkg::K_BRAKE);
			out_q.drive_enable <= nz_q;
			out_q.move_phase   <= job_q.phase;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`TMPB_ASSERT(a_div_rem_below, (state_q != tmpb_pkg::BK_DIV) || (rem_q < den100_q), "divider remainder not below divisor")
	`TMPB_ASSERT(a_div_nonzero, (state_q != tmpb_pkg::BK_DIV) || (den100_q != '0), "divider started with zero divisor")
	`TMPB_ASSERT_NEXT(a_load_valid, load_out, out_valid_q, "result load did not raise valid")
	`TMPB_ASSERT_NEXT(a_pop_start, q_pop, state_q == tmpb_pkg::BK_PROD, "popped job not started")

endmodule

`default_nettype wire

// ===== rtl/trapezoid_move_profile_brake_top.sv =====
// Trapezoid move profile with reverse braking, one wheel.
// Channels: s_* takes one beat per control tick (restart flag and signed
//   encoder count); m_* returns one beat per tick (duty, reverse,
//   drive_enable, move_phase); cfg_* writes the seven profile registers.
// The front end classifies a beat in its accept cycle and queues a job in a
//   two-entry queue; the back end computes the duty with multipliers and a
//   16-step serial divider.
// The back end works through pop, the product terms, the clamp, the multiply,
//   16 divide steps and the output load, in that order, and pops the next job
//   only after the output load.
// s_tready stays high until the queue holds two jobs, so up to two ticks
//   can be taken ahead of the back end.
// When m_tready is low the result waits in the output register; the back
//   end finishes its current job and then holds, and the queue fills.
// Reset clears phase to profiling, the last magnitude to zero, empties the
//   queue and loads the register defaults. cfg_ready is always high; write
//   only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_move_profile_brake_top #(
	parameter int COUNT_BITS = 24,
	localparam int SDataW = ((COUNT_BITS + 1 + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// s_tdata: [0] restart, [COUNT_BITS:1] enc_count, rest zero
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [SDataW-1:0]             s_tdata,
	// m_tdata: [15:0] duty, [16] reverse, [17] drive_enable,
	//          [19:18] move_phase, rest zero
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [tmpb_pkg::OUT_W-1:0]         m_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tmpb_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [tmpb_pkg::CFG_W-1:0]    cfg_data
);

	tmpb_pkg::cfg_t cfg_q;
	tmpb_pkg::job_t push_job;
	tmpb_pkg::job_t head_job;
	tmpb_pkg::res_t res;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	assign cfg_ready = 1'b1;

	// Profile registers; unused indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= tmpb_pkg::RST_TARGET;
			cfg_q.max_pct   <= tmpb_pkg::RST_MAX_PCT;
			cfg_q.min_pct   <= tmpb_pkg::RST_MIN_PCT;
			cfg_q.ramp_up   <= tmpb_pkg::RST_RAMP_UP;
			cfg_q.ramp_down <= tmpb_pkg::RST_RAMP_DOWN;
			cfg_q.brake_pct <= tmpb_pkg::RST_BRAKE_PCT;
			cfg_q.period    <= tmpb_pkg::RST_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (tmpb_pkg::reg_idx_t'(cfg_index))
				tmpb_pkg::REG_TARGET:    cfg_q.target    <= cfg_data[tmpb_pkg::MAG_W-1:0];
				tmpb_pkg::REG_MAX_PCT:   cfg_q.max_pct   <= cfg_data[tmpb_pkg::PCT_W-1:0];
				tmpb_pkg::REG_MIN_PCT:   cfg_q.min_pct   <= cfg_data[tmpb_pkg::PCT_W-1:0];
				tmpb_pkg::REG_RAMP_UP:   cfg_q.ramp_up   <= cfg_data[tmpb_pkg::RAMP_W-1:0];
				tmpb_pkg::REG_RAMP_DOWN: cfg_q.ramp_down <= cfg_data[tmpb_pkg::RAMP_W-1:0];
				tmpb_pkg::REG_BRAKE_PCT: cfg_q.brake_pct <= cfg_data[tmpb_pkg::PCT_W-1:0];
				tmpb_pkg::REG_PERIOD:    cfg_q.period    <= cfg_data[tmpb_pkg::RAMP_W-1:0];
				default:                 cfg_q           <= cfg_q;
			endcase
		end
	end

	tmpb_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.restart   (s_tdata[0]),
		.enc_count (s_tdata[COUNT_BITS:1]),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	tmpb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (push_job),
		.pop    (q_pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	tmpb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack the result beat
	assign m_tdata = {4'd0, res.move_phase, res.drive_enable, res.reverse, res.duty};

endmodule

`default_nettype wire

// ===== sim/trapezoid_move_profile_brake_top_tb.sv =====
// Testbench for trapezoid_move_profile_brake_top: directed and random encoder-count moves,
// each result beat checked against an in-bench prediction of duty, direction and phase.
// Depends on rtl/tmpb_pkg.sv and rtl/trapezoid_move_profile_brake_top.sv.
`timescale 1ns / 1ps

module trapezoid_move_profile_brake_top_tb;

	import tmpb_pkg::*;

	localparam int COUNT_BITS = 24;
	localparam int SDATA_W = ((COUNT_BITS + 1 + 7) / 8) * 8;
	localparam int LATENCY = 21;
	localparam int SETTLE_CYCLES = LATENCY + 10;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Predicted register file and profile state
	longint c_target = RST_TARGET;
	longint c_max = RST_MAX_PCT;
	longint c_min = RST_MIN_PCT;
	longint c_rup = RST_RAMP_UP;
	longint c_rdown = RST_RAMP_DOWN;
	longint c_brake = RST_BRAKE_PCT;
	longint c_period = RST_PERIOD;
	phase_t prof_phase = PH_PROFILE;
	longint prev_mag = 0;

	res_t drive_pending[$];
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned ticks_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	longint cycles = 0;

	trapezoid_move_profile_brake_top #(.COUNT_BITS(COUNT_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Work out the drive for one tick and advance the predicted state
	function automatic res_t drive_for_tick(input bit restart, input logic [COUNT_BITS-1:0] enc);
		res_t r;
		logic [COUNT_BITS-1:0] inv;
		longint mag, rem, span, n, d, num, den;
		bit brake;
		if (enc[COUNT_BITS-1]) begin
			inv = ~enc;
			mag = inv;
			mag = mag + 1;
		end else begin
			mag = enc;
		end
		if (mag > longint'(MAG_MAX))
			mag = MAG_MAX;
		brake = 1'b0;
		num = 0;
		den = 1;
		if (restart) begin
			prof_phase = PH_PROFILE;
			prev_mag = 0;
		end
		if (prof_phase != PH_PROFILE) begin
			if (mag <= prev_mag)
				prof_phase = PH_DONE;
			else
				brake = 1'b1;
		end else begin
			rem = c_target - mag;
			if (rem <= 0) begin
				prof_phase = PH_BRAKE;
				brake = 1'b1;
			end else begin
				span = c_max - c_min;
				d = 1;
				// slow-down ramp wins over the speed-up ramp
				if (rem < c_rdown) begin
					d = c_rdown;
					n = c_min * d + rem * span;
				end else if (mag < c_rup) begin
					d = c_rup;
					n = c_min * d + mag * span;
				end else begin
					n = c_max;
				end
				if (n < c_min * d)
					n = c_min * d;
				if (n <= 0) begin
					prof_phase = PH_BRAKE;
					brake = 1'b1;
				end else begin
					num = n;
					den = d;
				end
			end
		end
		if (brake) begin
			num = c_brake;
			den = 1;
		end
		if (num > 0) begin
			if (num > 100 * den)
				num = 100 * den;
			r.duty = DUTY_W'((c_period * num) / (100 * den));
			r.reverse = brake;
			r.drive_enable = 1'b1;
		end else begin
			r.duty = '0;
			r.reverse = 1'b0;
			r.drive_enable = 1'b0;
		end
		r.move_phase = prof_phase;
		prev_mag = mag;
		return r;
	endfunction

	// Signed count word for a distance; past the 23-bit range a negative count pins at -2^23
	function automatic logic [COUNT_BITS-1:0] count_word(input longint pos, input bit neg);
		if (neg && pos > longint'(MAG_MAX))
			return {1'b1, {(COUNT_BITS-1){1'b0}}};
		if (pos > longint'(MAG_MAX))
			pos = MAG_MAX;
		return neg ? COUNT_BITS'(-pos) : COUNT_BITS'(pos);
	endfunction

	function automatic int unsigned pick_pct();
		case ($urandom_range(9))
			0: return 0;
			1: return 100;
			2: return $urandom & 32'h7FFFFF;
			default: return $urandom_range(0, 100);
		endcase
	endfunction

	function automatic int unsigned pick_ramp(input int unsigned cap);
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			2: return $urandom & 32'h7FFFFF;
			default: return $urandom_range(1, cap);
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s at result %0d: expected %0d, got %0d",
				what, results_seen, want, got);
	endtask

	// Send one tick beat and queue its predicted drive on acceptance
	task automatic send_tick(input bit restart, input logic [COUNT_BITS-1:0] enc);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(SDATA_W-COUNT_BITS-1){1'b0}}, enc, restart};
		do @(posedge clk); while (!s_tready);
		drive_pending.push_back(drive_for_tick(restart, enc));
		ticks_sent++;
	endtask

	// Drop valid, drain all expected beats, then let the back end settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (drive_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; valid stays high unless this is the last write of a burst
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
		case (idx)
			REG_TARGET: c_target = value & 32'h7FFFFF;
			REG_MAX_PCT: c_max = value & 32'h7F;
			REG_MIN_PCT: c_min = value & 32'h7F;
			REG_RAMP_UP: c_rup = value & 32'hFFFF;
			REG_RAMP_DOWN: c_rdown = value & 32'hFFFF;
			REG_BRAKE_PCT: c_brake = value & 32'h7F;
			REG_PERIOD: c_period = value & 32'hFFFF;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int unsigned tgt, input int unsigned max_pct,
			input int unsigned min_pct, input int unsigned rup, input int unsigned rdown,
			input int unsigned brake_pct, input int unsigned period);
		wait_idle();
		write_reg(REG_TARGET, tgt, 1'b0);
		write_reg(REG_MAX_PCT, max_pct, 1'b0);
		write_reg(REG_MIN_PCT, min_pct, 1'b0);
		write_reg(REG_RAMP_UP, rup, 1'b0);
		write_reg(REG_RAMP_DOWN, rdown, 1'b0);
		write_reg(REG_BRAKE_PCT, brake_pct, 1'b0);
		write_reg(REG_PERIOD, period, 1'b1);
	endtask

	task automatic randomize_settings();
		int unsigned tgt, cap, period;
		case ($urandom_range(9))
			0: tgt = 0;
			1: tgt = MAG_MAX;
			2: tgt = $urandom & 32'h7FFFFF;
			default: tgt = $urandom_range(1, 4000);
		endcase
		cap = (tgt / 2 + 1 > 65535) ? 65535 : tgt / 2 + 1;
		case ($urandom_range(9))
			0: period = 1;
			1: period = 65535;
			2: period = 0;
			default: period = $urandom_range(1, 65535);
		endcase
		apply_settings(tgt, pick_pct(), pick_pct(), pick_ramp(cap), pick_ramp(cap),
			pick_pct(), period);
	endtask

	// One move: restart, climb to the target, then a braking tail
	task automatic run_move();
		longint pos, step_max;
		int unsigned n_tail;
		bit neg;
		neg = $urandom_range(1);
		step_max = c_target / 12 + 1;
		pos = $urandom_range(0, step_max);
		send_tick(1'b1, count_word(pos, neg));
		while (pos < c_target) begin
			case ($urandom_range(19))
				0: send_tick(1'($urandom_range(1)), COUNT_BITS'($urandom));
				1: send_tick(1'b0, count_word(pos, neg));
				default: begin
					pos += $urandom_range(1, step_max);
					send_tick(1'b0, count_word(pos, neg));
				end
			endcase
		end
		n_tail = $urandom_range(2, 6);
		repeat (n_tail) begin
			case ($urandom_range(3))
				2: pos += $urandom_range(1, 50);
				3: pos = (pos > 20) ? pos - $urandom_range(0, 20) : 0;
				default: ;
			endcase
			send_tick(1'b0, count_word(pos, neg));
		end
	endtask

	// Reset register values: speed-up ramp, slow-down ramp, target, brake, done, rise in done
	task automatic test_default_profile();
		send_tick(1'b1, count_word(0, 1'b0));
		send_tick(1'b0, count_word(50, 1'b0));
		send_tick(1'b0, count_word(300, 1'b1));
		send_tick(1'b0, count_word(360, 1'b0));
		send_tick(1'b0, count_word(360, 1'b0));
		send_tick(1'b0, count_word(400, 1'b0));
		send_tick(1'b0, count_word(longint'(MAG_MAX) + 1, 1'b1));
		send_tick(1'b0, count_word(MAG_MAX, 1'b0));
	endtask

	// Zero speed, zero brake, percents above 100, zero ramps, tiny period, bad index
	task automatic test_special_cases();
		apply_settings(MAG_MAX, 0, 0, 0, 0, 0, 65535);
		send_tick(1'b1, count_word(1, 1'b0));
		send_tick(1'b0, count_word(2, 1'b0));
		send_tick(1'b0, count_word(2, 1'b0));
		apply_settings(1000, 127, 127, 500, 500, 127, 65535);
		send_tick(1'b1, count_word(0, 1'b0));
		send_tick(1'b0, count_word(700, 1'b1));
		send_tick(1'b0, count_word(1000, 1'b1));
		apply_settings(MAG_MAX, 100, 0, 65535, 65535, 100, 1);
		send_tick(1'b1, count_word(0, 1'b0));
		send_tick(1'b1, count_word(MAG_MAX, 1'b1));
		send_tick(1'b1, count_word(longint'(MAG_MAX) - 1, 1'b0));
		wait_idle();
		write_reg(REG_UNUSED, 32'h7FFFFF, 1'b1);
		send_tick(1'b1, count_word(100, 1'b0));
	endtask

	task automatic test_random_moves(input int unsigned snd, input int unsigned rcv,
			input int unsigned n_ticks);
		int unsigned goal, next_cfg;
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		goal = ticks_sent + n_ticks;
		while (ticks_sent < goal) begin
			randomize_settings();
			next_cfg = ticks_sent + 70;
			while (ticks_sent < next_cfg && ticks_sent < goal) begin
				if ($urandom_range(9) == 0)
					send_tick(1'($urandom_range(1)), COUNT_BITS'($urandom));
				else
					run_move();
			end
		end
	endtask

	// Check each result beat against the oldest prediction; randomize ready
	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_pending.size() == 0) begin
				flag_mismatch("unexpected beat", -1, m_tdata);
			end else begin
				want = drive_pending.pop_front();
				if (m_tdata[15:0] !== want.duty)
					flag_mismatch("duty", want.duty, m_tdata[15:0]);
				if (m_tdata[16] !== want.reverse)
					flag_mismatch("reverse", want.reverse, m_tdata[16]);
				if (m_tdata[17] !== want.drive_enable)
					flag_mismatch("drive_enable", want.drive_enable, m_tdata[17]);
				if (m_tdata[19:18] !== want.move_phase)
					flag_mismatch("move_phase", want.move_phase, m_tdata[19:18]);
			end
			results_seen++;
		end
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle_pct = 15;
		rcv_idle_pct = 74;
		test_default_profile();
		test_special_cases();
		test_random_moves(15, 74, 630);
		test_random_moves(74, 15, 630);
		test_random_moves(0, 0, 640);
		wait_idle();
		if (mismatches == 0 && drive_pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
